[rtl/pps_pkg.sv]
// ----------------------------------------------------------------------------
// pps_pkg
// types, codes and helpers shared by the priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst_len;
        logic [7:0]  prio;
    } t_in_item;

    typedef struct packed {
        logic [31:0] tick_time;
        logic        ran;
        logic [3:0]  served_slot;
        logic        finished;
        logic [31:0] task_wait;
        logic [31:0] task_turnaround;
        logic        all_finished;
        logic [31:0] sum_wait;
        logic [31:0] sum_turnaround;
    } t_out_item;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] remaining;
        logic [7:0]  prio;
        logic [31:0] wait_time;
        logic [31:0] last_run;
    } t_row;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_UPD_GAP,
        ST_UPD_WAIT,
        ST_UPD_WRITE
    } t_state;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

[rtl/pps_task_mem.sv]
// ----------------------------------------------------------------------------
// pps_task_mem
// task slot table, one write port and one registered read port
// ----------------------------------------------------------------------------
module pps_task_mem
    import pps_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_row          i_wrow,
    input  logic [AW-1:0] i_raddr,
    output t_row          o_rrow
);

    t_row r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wrow;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rrow <= r_mem[i_raddr];
    end

endmodule

[rtl/preemptive_priority_scheduler_top.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// tick-driven preemptive priority scheduler over a table of task slots
// ----------------------------------------------------------------------------
// load item: accepted while idle, ready again the next cycle
// tick item: the result is registered and the input is ready again after the
//   one-slot-per-cycle scan, the last registered read and a three-step update
//   of the chosen slot
// a waiting result holds the update step of the following tick
// synchronous active-low reset clears valid bits, time, totals and control
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top
    import pps_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IW = $clog2(TASK_SLOTS);

    t_state r_state, n_state;

    logic [TASK_SLOTS-1:0] r_valid;
    logic [TASK_SLOTS-1:0] r_done;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_row_idx;
    logic                  r_row_vld;
    t_row                  rd_row;

    logic                  r_have;
    logic [IW-1:0]         r_best_idx;
    t_row                  r_best;
    logic [1:0]            r_pend;

    logic [31:0]           r_now;
    logic [31:0]           r_total_wait;
    logic [31:0]           r_total_turn;
    logic [31:0]           r_gap;
    logic [15:0]           r_rem;
    logic [31:0]           r_turn;
    logic [31:0]           r_wait_new;
    logic                  r_fin;

    logic                  r_out_valid;
    t_out_item             r_out_item;

    logic                  in_acc;
    logic                  load_acc;
    logic                  tick_acc;
    logic                  load_ok;
    logic [31:0]           slot_ext;
    logic [IW-1:0]         load_addr;
    logic                  out_free;
    logic                  upd_go;
    logic                  scanning;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    t_row                  mem_wrow;

    logic                  row_elig;
    logic                  row_pend;
    logic                  fin_now;
    logic [31:0]           n_total_wait;
    logic [31:0]           n_total_turn;
    logic [31:0]           best_idx_ext;

    assign in_acc    = i_in_valid && o_in_ready;
    assign load_acc  = in_acc && (i_in_item.op == OP_LOAD);
    assign tick_acc  = in_acc && (i_in_item.op == OP_TICK);
    assign slot_ext  = {28'd0, i_in_item.slot};
    assign load_ok   = slot_ext < 32'(TASK_SLOTS);
    assign load_addr = slot_ext[IW-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (tick_acc) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_idx == IW'(TASK_SLOTS - 1)) n_state = ST_SCAN_LAST;
            end
            ST_SCAN_LAST: n_state = ST_UPD_GAP;
            ST_UPD_GAP:   n_state = ST_UPD_WAIT;
            ST_UPD_WAIT:  n_state = ST_UPD_WRITE;
            ST_UPD_WRITE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        scanning   = 1'b0;
        upd_go     = 1'b0;
        case (r_state)
            ST_IDLE:      o_in_ready = 1'b1;
            ST_SCAN:      scanning   = 1'b1;
            ST_UPD_WRITE: upd_go     = out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign fin_now      = r_have && r_fin;
    assign n_total_wait = fin_now ? sat_add(r_total_wait, r_wait_new) : r_total_wait;
    assign n_total_turn = fin_now ? sat_add(r_total_turn, r_turn) : r_total_turn;
    assign best_idx_ext = 32'(r_best_idx);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = load_addr;
        mem_wrow  = '0;
        if (load_acc && load_ok) begin
            mem_we              = 1'b1;
            mem_wrow.arrival    = i_in_item.arrival;
            mem_wrow.remaining  = (i_in_item.burst_len == 16'd0) ? 16'd1
                                                                 : i_in_item.burst_len;
            mem_wrow.prio       = i_in_item.prio;
            mem_wrow.wait_time  = 32'd0;
            mem_wrow.last_run   = {16'd0, i_in_item.arrival};
        end else if (upd_go && r_have) begin
            mem_we              = 1'b1;
            mem_waddr           = r_best_idx;
            mem_wrow.arrival    = r_best.arrival;
            mem_wrow.remaining  = r_rem;
            mem_wrow.prio       = r_best.prio;
            mem_wrow.wait_time  = r_wait_new;
            mem_wrow.last_run   = sat_add(r_now, 32'd1);
        end
    end

    pps_task_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wrow  (mem_wrow),
        .i_raddr (r_idx),
        .o_rrow  (rd_row)
    );

    // scan compare on the registered row
    assign row_pend = r_row_vld && r_valid[r_row_idx] && !r_done[r_row_idx];
    assign row_elig = row_pend && ({16'd0, rd_row.arrival} <= r_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_now        <= 32'd0;
            r_total_wait <= 32'd0;
            r_total_turn <= 32'd0;
            r_out_valid  <= 1'b0;
            r_row_vld    <= 1'b0;
            r_idx        <= '0;
            r_have       <= 1'b0;
            r_pend       <= 2'd0;
        end else begin
            r_row_vld <= scanning;
            r_row_idx <= r_idx;
            if (scanning) begin
                r_idx <= r_idx + IW'(1);
            end
            if (load_acc && load_ok) begin
                r_valid[load_addr] <= 1'b1;
                r_done[load_addr]  <= 1'b0;
            end
            if (tick_acc) begin
                r_idx  <= '0;
                r_have <= 1'b0;
                r_pend <= 2'd0;
            end
            if (row_pend && r_pend != 2'd2) begin
                r_pend <= r_pend + 2'd1;
            end
            if (row_elig && (!r_have || rd_row.prio > r_best.prio)) begin
                r_have     <= 1'b1;
                r_best     <= rd_row;
                r_best_idx <= r_row_idx;
            end
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (upd_go) begin
                if (fin_now) begin
                    r_done[r_best_idx] <= 1'b1;
                end
                r_total_wait <= n_total_wait;
                r_total_turn <= n_total_turn;
                r_now        <= sat_add(r_now, 32'd1);
                r_out_valid  <= 1'b1;
            end
        end
    end

    // update datapath of the chosen slot
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPD_GAP) begin
            r_gap  <= (r_now >= r_best.last_run) ? (r_now - r_best.last_run) : 32'd0;
            r_rem  <= (r_best.remaining != 16'd0) ? (r_best.remaining - 16'd1) : 16'd0;
            r_turn <= r_now - {16'd0, r_best.arrival};
        end
        if (r_state == ST_UPD_WAIT) begin
            r_wait_new <= sat_add(r_best.wait_time, r_gap);
            r_turn     <= sat_add(r_turn, 32'd1);
            r_fin      <= (r_rem == 16'd0);
        end
        if (upd_go) begin
            r_out_item.tick_time       <= r_now;
            r_out_item.ran             <= r_have;
            r_out_item.served_slot     <= r_have ? best_idx_ext[3:0] : 4'd0;
            r_out_item.finished        <= fin_now;
            r_out_item.task_wait       <= r_have ? r_wait_new : 32'd0;
            r_out_item.task_turnaround <= fin_now ? r_turn : 32'd0;
            r_out_item.all_finished    <= (r_pend == 2'd0) || ((r_pend == 2'd1) && fin_now);
            r_out_item.sum_wait        <= n_total_wait;
            r_out_item.sum_turnaround  <= n_total_turn;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[test/tb_preemptive_priority_scheduler_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler_top
// drives load and tick items through the scheduler with random stalls on
// both channels, predicts every tick result from a local copy of the slot
// table and compares each result field by field in arrival order
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler_top;
    import pps_pkg::*;

    localparam int SLOTS        = 16;
    localparam int TICK_LATENCY = SLOTS + 5;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 205;
    localparam int LOAD_PCT [PHASES] = '{30, 45, 20, 60, 35, 25, 40};

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    // local copy of the scheduler state
    bit          m_valid     [SLOTS];
    logic [15:0] m_arrival   [SLOTS];
    logic [15:0] m_remaining [SLOTS];
    logic [7:0]  m_prio      [SLOTS];
    bit          m_done      [SLOTS];
    logic [31:0] m_wait      [SLOTS];
    logic [31:0] m_last_run  [SLOTS];
    logic [31:0] m_now;
    logic [31:0] m_total_wait;
    logic [31:0] m_total_turn;

    t_out_item pending_outcomes[$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        ready_hold  = 0;
    int        est_now     = 0;
    bit        no_idle     = 1'b0;

    preemptive_priority_scheduler_top #(
        .TASK_SLOTS(SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] clip_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic schedule_step(input t_in_item it);
        int          pick;
        logic [7:0]  best;
        logic [31:0] t;
        logic [31:0] gap;
        logic [31:0] turn;
        bit          all_done;
        t_out_item   r;
        if (it.op == OP_LOAD) begin
            m_valid[it.slot]     = 1'b1;
            m_arrival[it.slot]   = it.arrival;
            m_remaining[it.slot] = (it.burst_len == 16'd0) ? 16'd1 : it.burst_len;
            m_prio[it.slot]      = it.prio;
            m_done[it.slot]      = 1'b0;
            m_wait[it.slot]      = 32'd0;
            m_last_run[it.slot]  = {16'd0, it.arrival};
            return;
        end
        t    = m_now;
        r    = '0;
        pick = -1;
        best = 8'd0;
        for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i] && !m_done[i] && {16'd0, m_arrival[i]} <= t) begin
                if (pick < 0 || m_prio[i] > best) begin
                    best = m_prio[i];
                    pick = i;
                end
            end
        end
        if (pick >= 0) begin
            gap = (t >= m_last_run[pick]) ? t - m_last_run[pick] : 32'd0;
            m_wait[pick]     = clip_add(m_wait[pick], gap);
            m_last_run[pick] = clip_add(t, 32'd1);
            if (m_remaining[pick] != 16'd0) m_remaining[pick] = m_remaining[pick] - 16'd1;
            r.ran         = 1'b1;
            r.served_slot = 4'(pick);
            r.task_wait   = m_wait[pick];
            if (m_remaining[pick] == 16'd0) begin
                turn = clip_add(t - {16'd0, m_arrival[pick]}, 32'd1);
                m_done[pick]      = 1'b1;
                r.finished        = 1'b1;
                r.task_turnaround = turn;
                m_total_wait      = clip_add(m_total_wait, m_wait[pick]);
                m_total_turn      = clip_add(m_total_turn, turn);
            end
        end
        m_now = clip_add(m_now, 32'd1);
        all_done = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (m_valid[i] && !m_done[i]) all_done = 1'b0;
        end
        r.tick_time      = t;
        r.all_finished   = all_done;
        r.sum_wait       = m_total_wait;
        r.sum_turnaround = m_total_turn;
        pending_outcomes.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic check_outcome(input t_out_item got);
        t_out_item want;
        if (pending_outcomes.size() == 0) begin
            $display("%0t: result with no item expected, actual %h", $time, got);
            mismatches++;
            return;
        end
        want = pending_outcomes.pop_front();
        compare_field("tick_time", want.tick_time, got.tick_time);
        compare_field("ran", 32'(want.ran), 32'(got.ran));
        compare_field("served_slot", 32'(want.served_slot), 32'(got.served_slot));
        compare_field("finished", 32'(want.finished), 32'(got.finished));
        compare_field("task_wait", want.task_wait, got.task_wait);
        compare_field("task_turnaround", want.task_turnaround, got.task_turnaround);
        compare_field("all_finished", 32'(want.all_finished), 32'(got.all_finished));
        compare_field("sum_wait", want.sum_wait, got.sum_wait);
        compare_field("sum_turnaround", want.sum_turnaround, got.sum_turnaround);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && out_ready) check_outcome(out_item);
            if (in_valid && in_ready) schedule_step(in_item);
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (no_idle) begin
            out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 19))
                0: begin
                    out_ready  <= 1'b0;
                    ready_hold <= $urandom_range(15, 40);
                end
                1, 2, 3, 4, 5: begin
                    out_ready  <= 1'b0;
                    ready_hold <= $urandom_range(0, 3);
                end
                default: begin
                    out_ready  <= 1'b1;
                    ready_hold <= $urandom_range(0, 8);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[preemptive_priority_scheduler_top] ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        if (it.op == OP_TICK) est_now++;
    endtask

    task automatic send_load(input int slot, input int arrival, input int burst,
                             input int prio);
        t_in_item it;
        it           = '0;
        it.op        = OP_LOAD;
        it.slot      = 4'(slot);
        it.arrival   = 16'(arrival);
        it.burst_len = 16'(burst);
        it.prio      = 8'(prio);
        send_item(it);
    endtask

    task automatic send_tick();
        t_in_item it;
        it           = '0;
        it.op        = OP_TICK;
        it.slot      = 4'($urandom_range(0, 15));
        it.arrival   = 16'($urandom_range(0, 65535));
        it.burst_len = 16'($urandom_range(0, 65535));
        it.prio      = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic test_idle_without_tasks();
        send_tick();
        send_tick();
    endtask

    task automatic test_field_extremes();
        send_load(15, 65535, 65535, 255);
        send_load(0, 0, 1, 0);
        send_tick();
        send_tick();
        // retire the never-arriving slot
        send_load(15, 0, 1, 255);
        send_tick();
    endtask

    task automatic test_priority_order();
        send_load(3, 0, 2, 200);
        send_load(5, 0, 2, 200);
        send_load(1, 0, 1, 100);
        repeat (5) send_tick();
    endtask

    task automatic test_zero_burst();
        send_load(7, 0, 0, 255);
        send_tick();
    endtask

    task automatic test_preemption();
        send_load(2, est_now, 4, 10);
        send_tick();
        send_tick();
        send_load(4, est_now, 2, 50);
        repeat (4) send_tick();
    endtask

    task automatic random_load();
        int r;
        int slot;
        int arrival;
        int burst;
        int prio;
        slot = $urandom_range(0, 15);
        r = $urandom_range(0, 99);
        if (r < 75) arrival = est_now + $urandom_range(0, 12);
        else if (r < 85) arrival = est_now - $urandom_range(0, 30);
        else if (r < 95) arrival = $urandom_range(0, 65535);
        else arrival = 0;
        if (arrival < 0) arrival = 0;
        if (arrival > 65535) arrival = 65535;
        r = $urandom_range(0, 99);
        if (r < 80) burst = $urandom_range(1, 6);
        else if (r < 88) burst = $urandom_range(7, 40);
        else if (r < 92) burst = 0;
        else if (r < 96) burst = $urandom_range(0, 65535);
        else burst = 65535;
        if ($urandom_range(0, 99) < 30) prio = 85 * $urandom_range(0, 3);
        else prio = $urandom_range(0, 255);
        send_load(slot, arrival, burst, prio);
    endtask

    task automatic test_random_mix();
        for (int p = 0; p < PHASES; p++) begin
            no_idle = (p == 2 || p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < LOAD_PCT[p]) random_load();
                else send_tick();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            m_valid[i]     = 1'b0;
            m_arrival[i]   = '0;
            m_remaining[i] = '0;
            m_prio[i]      = '0;
            m_done[i]      = 1'b0;
            m_wait[i]      = '0;
            m_last_run[i]  = '0;
        end
        m_now        = '0;
        m_total_wait = '0;
        m_total_turn = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_without_tasks();
        test_field_extremes();
        test_priority_order();
        test_zero_burst();
        test_preemption();
        test_random_mix();

        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4 * TICK_LATENCY) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("[preemptive_priority_scheduler_top] OK");
        end else begin
            $display("[preemptive_priority_scheduler_top] ERROR");
        end
        $finish;
    end

endmodule
